// ===== design/iee_pkg.sv =====
// Shared types, character codes and operator decode for the expression evaluator.
package iee_pkg;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_APPLY,
    ST_MUL,
    ST_DIV,
    ST_SIGN,
    ST_EMIT
  } state_t;

  // Pending operator codes
  typedef enum logic [2:0] {
    OP_PLUS,
    OP_MINUS,
    OP_TIMES,
    OP_DIVIDE,
    OP_DISCARD
  } op_t;

  // ASCII codes of interest
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_TIMES  = 8'h2A;
  localparam logic [7:0] CH_DIVIDE = 8'h2F;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  // Map a character onto the operator it opens
  function automatic op_t op_of(input logic [7:0] c);
    op_t op;
    case (c)
      CH_PLUS:   op = OP_PLUS;
      CH_MINUS:  op = OP_MINUS;
      CH_TIMES:  op = OP_TIMES;
      CH_DIVIDE: op = OP_DIVIDE;
      default:   op = OP_DISCARD;
    endcase
    return op;
  endfunction

endpackage

// ===== design/iee_if.sv =====
// Valid/ready channel interfaces for the character input and the result output.
interface iee_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       last_char;

  modport source (output valid, char_code, last_char, input ready);
  modport sink   (input valid, char_code, last_char, output ready);
endinterface

interface iee_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] value;
  logic               divide_error;

  modport source (output valid, value, divide_error, input ready);
  modport sink   (input valid, value, divide_error, output ready);
endinterface

// ===== design/infix_expression_evaluator_core.sv =====
// Streaming infix expression evaluator: digits, spaces and + - * / one byte per beat.
// A digit or space is taken in the idle state. An operator or last character then passes
// the apply state, then the multiply loop when it closes a product, or the divide loop and
// sign state when it closes a quotient by a nonzero number. A last character then waits in
// the emit state until the output register is free. Input is ready only in the idle state.
// Reset (rst_n low, synchronous) clears the sequencer, the expression state and output valid.
module infix_expression_evaluator_core #(
  parameter int WORD_BITS = 32
) (
  input  logic            clk,
  input  logic            rst_n,
  iee_in_if.sink          in_ch,
  iee_out_if.source       out_ch
);

  localparam int W  = WORD_BITS;
  localparam int CW = $clog2(WORD_BITS);

  // Sequencer and expression state
  iee_pkg::state_t state_r, state_nxt;
  iee_pkg::op_t    pend_op_r, pend_op_nxt;
  iee_pkg::op_t    char_op_r, char_op_nxt;
  logic            last_r, last_nxt;
  logic [W-1:0]    cur_r, cur_nxt;
  logic [W-1:0]    closed_r, closed_nxt;
  logic [W-1:0]    open_r, open_nxt;
  logic            fault_r, fault_nxt;

  // Shared shift/add unit registers
  logic [W-1:0]    acc_r, acc_nxt;
  logic [W-1:0]    sh_r, sh_nxt;
  logic [W-1:0]    opb_r, opb_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            neg_q_r, neg_q_nxt;

  // Output register
  logic               out_valid_r, out_valid_nxt;
  logic signed [31:0] out_value_r, out_value_nxt;
  logic               out_err_r, out_err_nxt;

  // Decode of the incoming beat
  logic         in_acc;
  logic         is_digit;
  logic         is_space;
  logic         need_apply;
  logic [3:0]   digit_val;
  logic [W-1:0] cur_dig;
  logic         out_free;
  iee_pkg::state_t done_state;

  // Shared adder
  logic [W-1:0] alu_a, alu_b;
  logic         alu_cin;
  logic [W:0]   alu_sum;
  logic [W-1:0] rem_sh;
  logic [W-1:0] open_mag, cur_mag;
  logic [W-1:0] diff_w;
  logic [7:0]   digit_off;

  assign in_acc     = in_ch.valid && in_ch.ready;
  assign is_digit   = (in_ch.char_code >= iee_pkg::CH_ZERO) &&
                      (in_ch.char_code <= iee_pkg::CH_NINE);
  assign is_space   = (in_ch.char_code == iee_pkg::CH_SPACE);
  assign need_apply = (!is_digit && !is_space) || in_ch.last_char;
  assign digit_off  = in_ch.char_code - iee_pkg::CH_ZERO;
  assign digit_val  = digit_off[3:0];
  // cur * 10 + digit as two shifts and two adds
  assign cur_dig    = (cur_r << 3) + (cur_r << 1) + W'(digit_val);
  assign out_free   = !out_valid_r || out_ch.ready;
  assign done_state = last_r ? iee_pkg::ST_EMIT : iee_pkg::ST_IDLE;

  // Magnitudes for the divider set-up
  assign open_mag = open_r[W-1] ? (W'(0) - open_r) : open_r;
  assign cur_mag  = cur_r[W-1]  ? (W'(0) - cur_r)  : cur_r;
  assign rem_sh   = {acc_r[W-2:0], sh_r[W-1]};
  assign diff_w   = alu_sum[W-1:0];

  // Shared adder operand selection
  always_comb begin
    alu_a   = closed_r;
    alu_b   = open_r;
    alu_cin = 1'b0;
    case (state_r)
      iee_pkg::ST_MUL: begin
        alu_a = acc_r;
        alu_b = sh_r;
      end
      iee_pkg::ST_DIV: begin
        alu_a   = rem_sh;
        alu_b   = ~opb_r;
        alu_cin = 1'b1;
      end
      default: begin
        alu_a = closed_r;
        alu_b = open_r;
      end
    endcase
  end

  assign alu_sum = {1'b0, alu_a} + {1'b0, alu_b} + (W+1)'(alu_cin);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      iee_pkg::ST_IDLE: begin
        if (in_acc && need_apply) state_nxt = iee_pkg::ST_APPLY;
      end
      iee_pkg::ST_APPLY: begin
        if (pend_op_r == iee_pkg::OP_TIMES) begin
          state_nxt = iee_pkg::ST_MUL;
        end else if (pend_op_r == iee_pkg::OP_DIVIDE && cur_r != '0) begin
          state_nxt = iee_pkg::ST_DIV;
        end else begin
          state_nxt = done_state;
        end
      end
      iee_pkg::ST_MUL: begin
        if (cnt_r == '0) state_nxt = done_state;
      end
      iee_pkg::ST_DIV: begin
        if (cnt_r == '0) state_nxt = iee_pkg::ST_SIGN;
      end
      iee_pkg::ST_SIGN: state_nxt = done_state;
      iee_pkg::ST_EMIT: begin
        if (out_free) state_nxt = iee_pkg::ST_IDLE;
      end
      default: state_nxt = iee_pkg::ST_IDLE;
    endcase
  end

  // Datapath and output control
  always_comb begin
    pend_op_nxt   = pend_op_r;
    char_op_nxt   = char_op_r;
    last_nxt      = last_r;
    cur_nxt       = cur_r;
    closed_nxt    = closed_r;
    open_nxt      = open_r;
    fault_nxt     = fault_r;
    acc_nxt       = acc_r;
    sh_nxt        = sh_r;
    opb_nxt       = opb_r;
    cnt_nxt       = cnt_r;
    neg_q_nxt     = neg_q_r;
    out_value_nxt = out_value_r;
    out_err_nxt   = out_err_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;

    case (state_r)
      iee_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (is_digit) cur_nxt = cur_dig;
          char_op_nxt = iee_pkg::op_of(in_ch.char_code);
          last_nxt    = in_ch.last_char;
        end
      end
      // Apply the pending operator to the number just closed
      iee_pkg::ST_APPLY: begin
        cur_nxt     = '0;
        pend_op_nxt = char_op_r;
        case (pend_op_r)
          iee_pkg::OP_PLUS: begin
            closed_nxt = alu_sum[W-1:0];
            open_nxt   = cur_r;
          end
          iee_pkg::OP_MINUS: begin
            closed_nxt = alu_sum[W-1:0];
            open_nxt   = W'(0) - cur_r;
          end
          iee_pkg::OP_TIMES: begin
            acc_nxt = '0;
            sh_nxt  = open_r;
            opb_nxt = cur_r;
            cnt_nxt = CW'(W - 1);
          end
          iee_pkg::OP_DIVIDE: begin
            if (cur_r == '0) begin
              open_nxt  = '0;
              fault_nxt = 1'b1;
            end else begin
              acc_nxt   = '0;
              sh_nxt    = open_mag;
              opb_nxt   = cur_mag;
              neg_q_nxt = open_r[W-1] ^ cur_r[W-1];
              cnt_nxt   = CW'(W - 1);
            end
          end
          default: begin
            // discard operator: number dropped
          end
        endcase
      end
      // Shift-and-add multiply, one multiplier bit a cycle
      iee_pkg::ST_MUL: begin
        acc_nxt = opb_r[0] ? alu_sum[W-1:0] : acc_r;
        sh_nxt  = sh_r << 1;
        opb_nxt = opb_r >> 1;
        cnt_nxt = cnt_r - CW'(1);
        if (cnt_r == '0) open_nxt = acc_nxt;
      end
      // Restoring divide on magnitudes, one quotient bit a cycle
      iee_pkg::ST_DIV: begin
        acc_nxt = alu_sum[W] ? diff_w : rem_sh;
        sh_nxt  = {sh_r[W-2:0], alu_sum[W]};
        cnt_nxt = cnt_r - CW'(1);
      end
      iee_pkg::ST_SIGN: begin
        open_nxt = neg_q_r ? (W'(0) - sh_r) : sh_r;
      end
      // Once the output register is free, load it and return to the reset state
      iee_pkg::ST_EMIT: begin
        if (out_free) begin
          out_value_nxt = 32'($signed(alu_sum[W-1:0]));
          out_err_nxt   = fault_r;
          out_valid_nxt = 1'b1;
          cur_nxt       = '0;
          pend_op_nxt   = iee_pkg::OP_PLUS;
          closed_nxt    = '0;
          open_nxt      = '0;
          fault_nxt     = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  // Control and expression state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= iee_pkg::ST_IDLE;
      pend_op_r   <= iee_pkg::OP_PLUS;
      cur_r       <= '0;
      closed_r    <= '0;
      open_r      <= '0;
      fault_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_op_r   <= pend_op_nxt;
      cur_r       <= cur_nxt;
      closed_r    <= closed_nxt;
      open_r      <= open_nxt;
      fault_r     <= fault_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    char_op_r   <= char_op_nxt;
    last_r      <= last_nxt;
    acc_r       <= acc_nxt;
    sh_r        <= sh_nxt;
    opb_r       <= opb_nxt;
    cnt_r       <= cnt_nxt;
    neg_q_r     <= neg_q_nxt;
    out_value_r <= out_value_nxt;
    out_err_r   <= out_err_nxt;
  end

  assign in_ch.ready         = (state_r == iee_pkg::ST_IDLE);
  assign out_ch.valid        = out_valid_r;
  assign out_ch.value        = out_value_r;
  assign out_ch.divide_error = out_err_r;

`ifndef NO_ASSERTIONS
  // A non-final digit needs no operator work
  a_digit_stays_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && is_digit && !in_ch.last_char) |=> (state_r == iee_pkg::ST_IDLE))
    else $error("digit beat left the idle state");

  // A new result only ever comes from the emit state
  a_result_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == iee_pkg::ST_EMIT))
    else $error("result raised outside emit");

  // After a result the expression state is back at reset
  a_emit_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == iee_pkg::ST_EMIT && out_free) |=>
      (closed_r == '0 && open_r == '0 && cur_r == '0 && !fault_r &&
       state_r == iee_pkg::ST_IDLE))
    else $error("state not cleared after result");

  // The divide fault is sticky until the result is taken into the output register
  a_fault_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (fault_r && !(state_r == iee_pkg::ST_EMIT && out_free)) |=> fault_r)
    else $error("divide fault lost mid-expression");
`endif

endmodule

// ===== test/tb_top.sv =====
// Testbench for the streaming infix expression evaluator: directed rows, random expressions.
`timescale 1ns / 1ps

module tb_top;

  localparam int CHAR_TARGET  = 1300;
  localparam int HOLD_CYCLES  = 300;
  localparam int IDLE_LIMIT   = 4000;
  localparam int DRAIN_CYCLES = 50;
  localparam int N_OPENING    = 23;

  // One expected result beat
  typedef struct packed {
    logic signed [31:0] value;
    logic               div_err;
  } calc_result_t;

  // One row of the opening table; pinned rows carry a hand-written result
  typedef struct packed {
    logic [7:0]         ch;
    logic               last;
    logic               pinned;
    logic signed [31:0] value;
    logic               div_err;
  } char_row_t;

  // Receiver stall patterns
  typedef enum int {
    RX_OPEN,
    RX_COIN,
    RX_EVERY4,
    RX_MOSTLY
  } rx_mode_t;

  logic clk = 1'b0;
  logic rst_n;

  iee_in_if  in_if ();
  iee_out_if out_if ();

  infix_expression_evaluator_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  // Clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Evaluator state mirrored by the predictor
  logic [31:0]  num_acc;
  iee_pkg::op_t op_pend;
  logic [31:0]  sum_closed;
  logic [31:0]  term_open;
  logic         fault;

  calc_result_t expr_results[$];
  logic [7:0]   expr_buf[$];

  int  n_fail = 0;
  int  n_chars = 0;
  int  n_exprs = 0;
  int  n_results = 0;
  int  n_div_seen = 0;
  int  burst_left = 0;
  int  push_left = 0;
  bit  hold_req = 1'b0;
  calc_result_t want;

  // Opening table: extremes of the byte, each operator, special cases
  char_row_t opening_rows [N_OPENING] = '{
    // single digit nine
    '{iee_pkg::CH_ZERO + 8'd9, 1'b1, 1'b1, 32'sd9, 1'b0},
    // 0-7/2 truncates toward zero
    '{iee_pkg::CH_ZERO,        1'b0, 1'b0, 32'sd0, 1'b0},
    '{iee_pkg::CH_MINUS,       1'b0, 1'b0, 32'sd0, 1'b0},
    '{iee_pkg::CH_ZERO + 8'd7, 1'b0, 1'b0, 32'sd0, 1'b0},
    '{iee_pkg::CH_DIVIDE,      1'b0, 1'b0, 32'sd0, 1'b0},
    '{iee_pkg::CH_ZERO + 8'd2, 1'b1, 1'b1, -32'sd3, 1'b0},
    // 6*7 closed by a space
    '{iee_pkg::CH_ZERO + 8'd6, 1'b0, 1'b0, 32'sd0, 1'b0},
    '{iee_pkg::CH_TIMES,       1'b0, 1'b0, 32'sd0, 1'b0},
    '{iee_pkg::CH_ZERO + 8'd7, 1'b0, 1'b0, 32'sd0, 1'b0},
    '{iee_pkg::CH_SPACE,       1'b1, 1'b1, 32'sd42, 1'b0},
    // division by zero
    '{iee_pkg::CH_ZERO + 8'd5, 1'b0, 1'b0, 32'sd0, 1'b0},
    '{iee_pkg::CH_DIVIDE,      1'b0, 1'b0, 32'sd0, 1'b0},
    '{iee_pkg::CH_ZERO,        1'b1, 1'b1, 32'sd0, 1'b1},
    // stray operator drops the next number; fault must have cleared
    '{iee_pkg::CH_ZERO + 8'd3, 1'b0, 1'b0, 32'sd0, 1'b0},
    '{8'h23,                   1'b0, 1'b0, 32'sd0, 1'b0},
    '{iee_pkg::CH_ZERO + 8'd4, 1'b0, 1'b0, 32'sd0, 1'b0},
    '{iee_pkg::CH_PLUS,        1'b0, 1'b0, 32'sd0, 1'b0},
    '{iee_pkg::CH_ZERO + 8'd2, 1'b1, 1'b0, 32'sd0, 1'b0},
    // lone operator as both first and last character
    '{iee_pkg::CH_PLUS,        1'b1, 1'b1, 32'sd0, 1'b0},
    // byte 00 as a leading stray operator
    '{8'h00,                   1'b0, 1'b0, 32'sd0, 1'b0},
    '{iee_pkg::CH_ZERO + 8'd5, 1'b1, 1'b1, 32'sd0, 1'b0},
    // byte FF as the closing character
    '{iee_pkg::CH_ZERO + 8'd4, 1'b0, 1'b0, 32'sd0, 1'b0},
    '{8'hFF,                   1'b1, 1'b1, 32'sd4, 1'b0}
  };

  function automatic void clear_calc();
    num_acc    = '0;
    op_pend    = iee_pkg::OP_PLUS;
    sum_closed = '0;
    term_open  = '0;
    fault      = 1'b0;
  endfunction

  // Signed quotient, truncated toward zero, wrapping at 32 bits
  function automatic logic [31:0] trunc_quot(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] ma;
    logic [31:0] mb;
    logic [31:0] q;
    ma = a[31] ? -a : a;
    mb = b[31] ? -b : b;
    q  = ma / mb;
    return (a[31] ^ b[31]) ? -q : q;
  endfunction

  // Fold the pending operator into the sum and term, then clear the number
  function automatic void apply_pending_op();
    case (op_pend)
      iee_pkg::OP_PLUS: begin
        sum_closed = sum_closed + term_open;
        term_open  = num_acc;
      end
      iee_pkg::OP_MINUS: begin
        sum_closed = sum_closed + term_open;
        term_open  = -num_acc;
      end
      iee_pkg::OP_TIMES: term_open = term_open * num_acc;
      iee_pkg::OP_DIVIDE: begin
        if (num_acc == '0) begin
          term_open = '0;
          fault     = 1'b1;
        end else begin
          term_open = trunc_quot(term_open, num_acc);
        end
      end
      default: ;
    endcase
    num_acc = '0;
  endfunction

  // Advance the predictor by one character; returns 1 when a result is due
  function automatic bit step_calc(input logic [7:0] c, input logic is_last,
                                   output calc_result_t res);
    logic is_digit;
    logic is_space;
    is_digit = (c >= iee_pkg::CH_ZERO) && (c <= iee_pkg::CH_NINE);
    is_space = (c == iee_pkg::CH_SPACE);
    res = '0;
    if (is_digit) num_acc = num_acc * 32'd10 + 32'(c - iee_pkg::CH_ZERO);
    if ((!is_digit && !is_space) || is_last) begin
      apply_pending_op();
      if (c == iee_pkg::CH_PLUS)        op_pend = iee_pkg::OP_PLUS;
      else if (c == iee_pkg::CH_MINUS)  op_pend = iee_pkg::OP_MINUS;
      else if (c == iee_pkg::CH_TIMES)  op_pend = iee_pkg::OP_TIMES;
      else if (c == iee_pkg::CH_DIVIDE) op_pend = iee_pkg::OP_DIVIDE;
      else                              op_pend = iee_pkg::OP_DISCARD;
    end
    if (!is_last) return 1'b0;
    res.value   = sum_closed + term_open;
    res.div_err = fault;
    clear_calc();
    return 1'b1;
  endfunction

  // Offer one character and wait for its beat; predict on acceptance
  task automatic send_char(input logic [7:0] c, input logic is_last, input logic pinned,
                           input logic signed [31:0] pin_value, input logic pin_err);
    calc_result_t res;
    in_if.valid     <= 1'b1;
    in_if.char_code <= c;
    in_if.last_char <= is_last;
    do @(posedge clk); while (!in_if.ready);
    n_chars++;
    if (step_calc(c, is_last, res)) begin
      if (pinned) begin
        res.value   = pin_value;
        res.div_err = pin_err;
      end
      expr_results.push_back(res);
    end
  endtask

  // Sender pacing: bursts of random length, random gaps, none while pushing
  task automatic pace_sender();
    if (push_left > 0) begin
      push_left--;
    end else if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(0, 15);
    end
  endtask

  // Append an operator; mostly the four arithmetic ones, now and then any byte
  function automatic bit push_operator();
    int pick;
    pick = $urandom_range(0, 19);
    if (pick < 5)       expr_buf.push_back(iee_pkg::CH_PLUS);
    else if (pick < 10) expr_buf.push_back(iee_pkg::CH_MINUS);
    else if (pick < 15) expr_buf.push_back(iee_pkg::CH_TIMES);
    else if (pick < 19) expr_buf.push_back(iee_pkg::CH_DIVIDE);
    else                expr_buf.push_back(8'($urandom_range(0, 255)));
    return (pick >= 15) && (pick < 19);
  endfunction

  // Build one random expression into expr_buf
  task automatic build_expression();
    int    kind;
    int    n_terms;
    int    n_dig;
    bit    after_div;
    string corner;
    expr_buf.delete();
    after_div = 1'b0;
    kind = $urandom_range(0, 99);
    if (kind < 4) begin
      // wrap-around corners: most negative over minus one, overflowing numbers
      case ($urandom_range(0, 2))
        0:       corner = "65536*32768/4294967295";
        1:       corner = "4294967295*4294967295";
        default: corner = "0-2147483648 / 99999999999";
      endcase
      for (int i = 0; i < corner.len(); i++) expr_buf.push_back(8'(corner[i]));
    end else if (kind < 12) begin
      // noise: any bytes at all
      repeat ($urandom_range(1, 8)) expr_buf.push_back(8'($urandom_range(0, 255)));
    end else begin
      if ($urandom_range(0, 19) == 0) after_div = push_operator();
      n_terms = $urandom_range(1, 6);
      for (int t = 0; t < n_terms; t++) begin
        if (t > 0) begin
          if ($urandom_range(0, 4) == 0) expr_buf.push_back(iee_pkg::CH_SPACE);
          after_div = push_operator();
          if ($urandom_range(0, 4) == 0) expr_buf.push_back(iee_pkg::CH_SPACE);
        end
        if ($urandom_range(0, after_div ? 4 : 11) == 0) begin
          expr_buf.push_back(iee_pkg::CH_ZERO);
        end else begin
          n_dig = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 12) : $urandom_range(1, 3);
          repeat (n_dig) expr_buf.push_back(iee_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
        end
      end
      case ($urandom_range(0, 19))
        0:       expr_buf.push_back(iee_pkg::CH_SPACE);
        1:       after_div = push_operator();
        default: ;
      endcase
    end
  endtask

  // Receiver: stall patterns of its own, plus one long hold-off on request
  initial begin
    rx_mode_t rx_mode;
    int       rx_left;
    int       rx_phase;
    int       hold_left;
    rx_mode   = RX_OPEN;
    rx_left   = 0;
    rx_phase  = 0;
    hold_left = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        if (rx_left == 0) begin
          rx_mode = rx_mode_t'($urandom_range(0, 3));
          rx_left = $urandom_range(20, 200);
        end
        rx_left--;
        rx_phase++;
        case (rx_mode)
          RX_OPEN:   out_if.ready <= 1'b1;
          RX_COIN:   out_if.ready <= 1'($urandom_range(0, 1));
          RX_EVERY4: out_if.ready <= (rx_phase % 4 == 0);
          default:   out_if.ready <= ($urandom_range(0, 9) != 0);
        endcase
      end
    end
  end

  // Result checker: each result beat against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      n_results++;
      if (out_if.divide_error) n_div_seen++;
      if (expr_results.size() == 0) begin
        $error("unexpected result: value %0d, divide_error %0b",
               out_if.value, out_if.divide_error);
        n_fail++;
      end else begin
        want = expr_results.pop_front();
        if (out_if.value !== want.value) begin
          $error("value: expected %0d, got %0d", want.value, out_if.value);
          n_fail++;
        end
        if (out_if.divide_error !== want.div_err) begin
          $error("divide_error: expected %0b, got %0b", want.div_err, out_if.divide_error);
          n_fail++;
        end
      end
    end
  end

  // Watchdog: too many cycles without a beat on either side
  initial begin
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) idle = 0;
      else idle++;
    end
    $display("timeout after %0d idle cycles, %0d results outstanding",
             idle, expr_results.size());
    $display("FAILED: results differ");
    $finish;
  end

  // Stimulus
  initial begin
    bit hold_done;
    bit drain_done;
    hold_done  = 1'b0;
    drain_done = 1'b0;
    rst_n           <= 1'b0;
    in_if.valid     <= 1'b0;
    in_if.char_code <= '0;
    in_if.last_char <= 1'b0;
    clear_calc();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // opening table
    foreach (opening_rows[i]) begin
      send_char(opening_rows[i].ch, opening_rows[i].last, opening_rows[i].pinned,
                opening_rows[i].value, opening_rows[i].div_err);
      if (opening_rows[i].last) n_exprs++;
      pace_sender();
    end

    // random expressions
    while (n_chars < CHAR_TARGET) begin
      if (!hold_done && n_chars >= 450) begin
        // receiver stalls long while the sender keeps offering
        hold_req  = 1'b1;
        push_left = 120;
        hold_done = 1'b1;
      end
      if (!drain_done && n_chars >= 900) begin
        // sender pauses until every result is home
        in_if.valid <= 1'b0;
        do @(posedge clk); while (expr_results.size() != 0);
        drain_done = 1'b1;
      end
      build_expression();
      foreach (expr_buf[i]) begin
        send_char(expr_buf[i], i == expr_buf.size() - 1, 1'b0, 32'sd0, 1'b0);
        pace_sender();
      end
      n_exprs++;
    end
    in_if.valid <= 1'b0;

    // wait for the tail, then a little longer for stray beats
    while (expr_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d characters in %0d expressions; %0d results checked, %0d with divide error.",
             n_chars, n_exprs, n_results, n_div_seen);
    $display("Included one %0d-cycle receiver hold-off and one sender pause to drain.",
             HOLD_CYCLES);
    if (n_fail == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/iee_pkg.sv
design/iee_if.sv
design/infix_expression_evaluator_core.sv
test/tb_top.sv
